/* design/point_store_radius_query_macros.svh */
// Assertion macros shared by the point store RTL.
`ifndef POINT_STORE_RADIUS_QUERY_MACROS_SVH
`define POINT_STORE_RADIUS_QUERY_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PSRQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("point store assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define PSRQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("point store assertion failed");

`endif

/* design/psrq_pkg.sv */
// Shared codes and types of the point store with radius query.
package psrq_pkg;

   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 3;
   localparam int TALLY_W  = 5;
   localparam int POS_W    = 10;

   localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RADIUS = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_COUNT  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_LENGTH = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NO_RANGE  = 3'd4;

   localparam logic [1:0] CELL_HOLD  = 2'd0;
   localparam logic [1:0] CELL_PUSH  = 2'd1;
   localparam logic [1:0] CELL_CLOSE = 2'd2;

   // Broadcast to every cell: what to load and from which position on.
   typedef struct packed {
      logic [1:0]       op;
      logic [POS_W-1:0] pos;
   } cell_ctl_type;

   // Head probe result of one stored point.
   typedef struct packed {
      logic valid;
      logic eq;
      logic hit;
   } probe_type;

endpackage

/* design/psrq_cell.sv */
// One storage cell of the point chain; loads from its newer or older neighbor.
module psrq_cell #(
   parameter int INDEX       = 0,
   parameter int COORD_WIDTH = 16
) (
   input  logic                         clock,
   input  psrq_pkg::cell_ctl_type       ctl,
   input  logic [COORD_WIDTH-1:0]       newer_x,
   input  logic [COORD_WIDTH-1:0]       newer_y,
   input  logic [COORD_WIDTH-1:0]       older_x,
   input  logic [COORD_WIDTH-1:0]       older_y,
   output logic [COORD_WIDTH-1:0]       x,
   output logic [COORD_WIDTH-1:0]       y
);

   localparam int PW = psrq_pkg::POS_W;

   logic [COORD_WIDTH-1:0] x_ff, x_in;
   logic [COORD_WIDTH-1:0] y_ff, y_in;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      case (ctl.op)
         psrq_pkg::CELL_PUSH: begin
            x_in = newer_x;
            y_in = newer_y;
         end
         psrq_pkg::CELL_CLOSE: begin
            // close up from the removed position toward the older end
            if (ctl.pos <= PW'(INDEX)) begin
               x_in = older_x;
               y_in = older_y;
            end
         end
         default: begin
            x_in = x_ff;
            y_in = y_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign x = x_ff;
   assign y = y_ff;

endmodule

/* design/psrq_probe.sv */
// Head probe: squares the point at the head of the chain, then compares.
module psrq_probe #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    smp_valid,
   input  logic [COORD_WIDTH-1:0]  head_x,
   input  logic [COORD_WIDTH-1:0]  head_y,
   input  logic [COORD_WIDTH-1:0]  qx,
   input  logic [COORD_WIDTH-1:0]  qy,
   input  logic [COORD_WIDTH-1:0]  rad,
   output psrq_pkg::probe_type     probe,
   output logic [COORD_WIDTH-1:0]  hit_x,
   output logic [COORD_WIDTH-1:0]  hit_y
);

   localparam int SQ_W = 2 * COORD_WIDTH;

   logic                   valid_ff, valid_in;
   logic                   eq_ff, eq_in;
   logic signed [SQ_W-1:0] xx_in, yy_in, lim_in;
   logic [SQ_W-1:0]        xx_ff, yy_ff, lim_ff;
   logic [COORD_WIDTH-1:0] x_ff, y_ff;
   logic [SQ_W:0]          sum;

   assign xx_in    = $signed(head_x) * $signed(head_x);
   assign yy_in    = $signed(head_y) * $signed(head_y);
   assign lim_in   = $signed(rad) * $signed(rad);
   assign valid_in = smp_valid;
   assign eq_in    = (head_x == qx) && (head_y == qy);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff <= lim_in;
      if (adv) begin
         eq_ff <= eq_in;
         xx_ff <= xx_in;
         yy_ff <= yy_in;
         x_ff  <= head_x;
         y_ff  <= head_y;
      end
   end

   assign sum = {1'b0, xx_ff} + {1'b0, yy_ff};

   assign probe.valid = valid_ff;
   assign probe.eq    = eq_ff;
   assign probe.hit   = sum <= {1'b0, lim_ff};
   assign hit_x       = x_ff;
   assign hit_y       = y_ff;

endmodule

/* design/point_store_radius_query.sv */
// Top level: bounded newest-first point store with match and radius queries.
//
//   channel   dir   tdata                           tuser               tlast
//   req_      in    px, py, radius                  func                -
//   rsp_      out   out_x, out_y, tally             status, has_point   last
//
// Push, pop and length go straight to the done state, which registers their word.
// Delete, radius query and count rotate all DEPTH cells past the head probe
// once, and no new request is taken until that rotation is done.
// Reset is synchronous: the entry count clears, cell contents stay unknown.
// While rsp_tready is low with a word held, the rotation freezes in place.
`include "point_store_radius_query_macros.svh"

module point_store_radius_query #(
   parameter int DEPTH       = 16,
   parameter int COORD_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // px, py, radius (from bit 0 up), zero padded to bytes
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     req_tdata,
   // func
   input  logic [psrq_pkg::FUNC_W-1:0]            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_x, out_y, tally (from bit 0 up), zero padded to bytes
   output logic [((2*COORD_WIDTH+psrq_pkg::TALLY_W+7)/8)*8-1:0] rsp_tdata,
   // status, has_point (from bit 0 up)
   output logic [psrq_pkg::STATUS_W:0]            rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int CW    = COORD_WIDTH;
   localparam int SW    = $clog2(DEPTH + 1);
   localparam int IW    = $clog2(DEPTH);
   localparam int PW    = psrq_pkg::POS_W;
   localparam int TW    = psrq_pkg::TALLY_W;
   localparam int RSP_W = ((2*CW + TW + 7) / 8) * 8;
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [psrq_pkg::FUNC_W-1:0]   func_ff, func_in;
   logic [CW-1:0]                 qx_ff, qx_in, qy_ff, qy_in, rad_ff, rad_in;
   logic [SW-1:0]                 step_ff, step_in;
   logic [SW-1:0]                 count_ff, count_in;
   logic [SW-1:0]                 tally_ff, tally_in;
   logic                          found_ff, found_in;
   logic [IW-1:0]                 pos_ff, pos_in;
   logic [IW-1:0]                 spos_ff;
   logic                          pend_ff, pend_in;
   logic [CW-1:0]                 pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;

   logic                          rsp_valid_ff;
   logic [psrq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                          rsp_has_ff;
   logic [CW-1:0]                 rsp_x_ff, rsp_y_ff;
   logic [TW-1:0]                 rsp_tally_ff;
   logic                          rsp_last_ff;

   logic                          emit_valid;
   logic [psrq_pkg::STATUS_W-1:0] emit_status;
   logic                          emit_has;
   logic [CW-1:0]                 emit_x, emit_y;
   logic [TW-1:0]                 emit_tally;
   logic                          emit_last;

   logic                          adv;
   logic                          accept;
   logic                          smp_valid;
   psrq_pkg::cell_ctl_type        ctl;
   psrq_pkg::probe_type           probe;
   logic [CW-1:0]                 hit_x, hit_y;
   logic [CW-1:0]                 cell_x [DEPTH];
   logic [CW-1:0]                 cell_y [DEPTH];

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign smp_valid  = (state_ff == S_WALK) && (step_ff < count_ff);

   // Cell 0 is the newest point; cell 0 wraps to the oldest cell for rotation.
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         psrq_cell #(.INDEX(k), .COORD_WIDTH(CW)) u_cell (
            .clock   (clock),
            .ctl     (ctl),
            .newer_x (qx_ff),
            .newer_y (qy_ff),
            .older_x (cell_x[(k+1) % DEPTH]),
            .older_y (cell_y[(k+1) % DEPTH]),
            .x       (cell_x[k]),
            .y       (cell_y[k])
         );
      end else begin : g_body
         psrq_cell #(.INDEX(k), .COORD_WIDTH(CW)) u_cell (
            .clock   (clock),
            .ctl     (ctl),
            .newer_x (cell_x[k-1]),
            .newer_y (cell_y[k-1]),
            .older_x (cell_x[(k+1) % DEPTH]),
            .older_y (cell_y[(k+1) % DEPTH]),
            .x       (cell_x[k]),
            .y       (cell_y[k])
         );
      end
   end

   psrq_probe #(.COORD_WIDTH(CW)) u_probe (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .smp_valid (smp_valid),
      .head_x    (cell_x[0]),
      .head_y    (cell_y[0]),
      .qx        (qx_ff),
      .qy        (qy_ff),
      .rad       (rad_ff),
      .probe     (probe),
      .hit_x     (hit_x),
      .hit_y     (hit_y)
   );

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      rad_in      = rad_ff;
      step_in     = step_ff;
      count_in    = count_ff;
      tally_in    = tally_ff;
      found_in    = found_ff;
      pos_in      = pos_ff;
      pend_in     = pend_ff;
      pend_x_in   = pend_x_ff;
      pend_y_in   = pend_y_ff;
      ctl.op      = psrq_pkg::CELL_HOLD;
      ctl.pos     = '0;
      emit_valid  = 1'b0;
      emit_status = psrq_pkg::STAT_OK;
      emit_has    = 1'b0;
      emit_x      = '0;
      emit_y      = '0;
      emit_tally  = '0;
      emit_last   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in  = req_tuser;
               qx_in    = req_tdata[CW-1:0];
               qy_in    = req_tdata[2*CW-1:CW];
               rad_in   = req_tdata[3*CW-1:2*CW];
               step_in  = '0;
               tally_in = '0;
               found_in = 1'b0;
               pend_in  = 1'b0;
               if (req_tuser inside {psrq_pkg::FUNC_DELETE, psrq_pkg::FUNC_RADIUS,
                                     psrq_pkg::FUNC_COUNT}) begin
                  state_in = S_WALK;
               end else if (req_tuser inside {psrq_pkg::FUNC_PUSH, psrq_pkg::FUNC_POP,
                                              psrq_pkg::FUNC_LENGTH}) begin
                  state_in = S_DONE;
               end
            end
         end
         S_WALK: begin
            if (adv) begin
               // rotate one place; after DEPTH steps the chain is back in order
               if (step_ff != DEPTH_S) begin
                  ctl.op  = psrq_pkg::CELL_CLOSE;
                  step_in = SW'(step_ff + 1'b1);
               end else begin
                  state_in = S_DONE;
               end
               if (probe.valid) begin
                  if (probe.eq) begin
                     tally_in = SW'(tally_ff + 1'b1);
                     if (!found_ff && func_ff == psrq_pkg::FUNC_DELETE) begin
                        found_in = 1'b1;
                        pos_in   = spos_ff;
                     end
                  end
                  // hold the newest hit back until the next one shows it is not last
                  if (func_ff == psrq_pkg::FUNC_RADIUS && probe.hit) begin
                     if (pend_ff) begin
                        emit_valid = 1'b1;
                        emit_has   = 1'b1;
                        emit_x     = pend_x_ff;
                        emit_y     = pend_y_ff;
                     end
                     pend_in   = 1'b1;
                     pend_x_in = hit_x;
                     pend_y_in = hit_y;
                  end
               end
            end
         end
         S_DONE: begin
            if (adv) begin
               state_in   = S_IDLE;
               pend_in    = 1'b0;
               emit_valid = 1'b1;
               emit_last  = 1'b1;
               case (func_ff)
                  psrq_pkg::FUNC_PUSH: begin
                     if (count_ff == DEPTH_S) begin
                        emit_status = psrq_pkg::STAT_FULL;
                     end else begin
                        ctl.op   = psrq_pkg::CELL_PUSH;
                        count_in = SW'(count_ff + 1'b1);
                     end
                  end
                  psrq_pkg::FUNC_POP: begin
                     if (count_ff == '0) begin
                        emit_status = psrq_pkg::STAT_EMPTY;
                     end else begin
                        ctl.op   = psrq_pkg::CELL_CLOSE;
                        count_in = SW'(count_ff - 1'b1);
                     end
                  end
                  psrq_pkg::FUNC_DELETE: begin
                     if (count_ff == '0) begin
                        emit_status = psrq_pkg::STAT_EMPTY;
                     end else if (found_ff) begin
                        ctl.op   = psrq_pkg::CELL_CLOSE;
                        ctl.pos  = PW'(pos_ff);
                        count_in = SW'(count_ff - 1'b1);
                     end else begin
                        emit_status = psrq_pkg::STAT_NOT_FOUND;
                     end
                  end
                  psrq_pkg::FUNC_RADIUS: begin
                     if (count_ff == '0) begin
                        emit_status = psrq_pkg::STAT_EMPTY;
                     end else if (pend_ff) begin
                        emit_has = 1'b1;
                        emit_x   = pend_x_ff;
                        emit_y   = pend_y_ff;
                     end else begin
                        emit_status = psrq_pkg::STAT_NO_RANGE;
                     end
                  end
                  psrq_pkg::FUNC_COUNT: begin
                     emit_tally = TW'(tally_ff);
                  end
                  psrq_pkg::FUNC_LENGTH: begin
                     emit_tally = TW'(count_ff);
                  end
                  default: begin
                     emit_valid = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         found_ff <= found_in;
         pend_ff  <= pend_in;
         if (adv) begin
            rsp_valid_ff <= emit_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      rad_ff    <= rad_in;
      step_ff   <= step_in;
      tally_ff  <= tally_in;
      pos_ff    <= pos_in;
      pend_x_ff <= pend_x_in;
      pend_y_ff <= pend_y_in;
      if (adv) begin
         spos_ff <= step_ff[IW-1:0];
      end
      if (adv && emit_valid) begin
         rsp_status_ff <= emit_status;
         rsp_has_ff    <= emit_has;
         rsp_x_ff      <= emit_x;
         rsp_y_ff      <= emit_y;
         rsp_tally_ff  <= emit_tally;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_tally_ff, rsp_y_ff, rsp_x_ff});
   assign rsp_tuser  = {rsp_has_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   `PSRQ_ASSERT_NEXT(a_count_moves_on_done, clock, reset, state_ff != S_DONE, $stable(count_ff))
   `PSRQ_ASSERT_NOW(a_idle_probe_empty, clock, reset, state_ff == S_IDLE, !probe.valid)
   `PSRQ_ASSERT_NOW(a_pend_radius_only, clock, reset, pend_ff, func_ff == psrq_pkg::FUNC_RADIUS && state_ff != S_IDLE)
   `PSRQ_ASSERT_NEXT(a_walk_ends, clock, reset, state_ff == S_WALK && step_ff == DEPTH_S && adv, state_ff == S_DONE)
   `PSRQ_ASSERT_NOW(a_found_delete_only, clock, reset, found_ff, func_ff == psrq_pkg::FUNC_DELETE)

endmodule

/* tb/point_store_radius_query_checker.sv */
// Checker for the point store: predicts every response word and compares it.
module point_store_radius_query_checker #(
   parameter int DEPTH   = 16,
   parameter int COORD_W = 16,
   parameter int REQ_W   = 48,
   parameter int RSP_W   = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [REQ_W-1:0]              req_tdata,
   input  logic [psrq_pkg::FUNC_W-1:0]   req_tuser,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [RSP_W-1:0]              rsp_tdata,
   input  logic [psrq_pkg::STATUS_W:0]   rsp_tuser,
   input  logic                          rsp_tlast,
   output int                            fail_count,
   output int                            rsp_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 100;
   localparam int FW        = psrq_pkg::FUNC_W;
   localparam int STW       = psrq_pkg::STATUS_W;
   localparam int TLW       = psrq_pkg::TALLY_W;

   typedef struct {
      logic [STW-1:0]            status;
      logic                      has_point;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [TLW-1:0]            tally;
      logic                      last;
   } rsp_word_type;

   logic signed [COORD_W-1:0] stored_x [DEPTH];
   logic signed [COORD_W-1:0] stored_y [DEPTH];
   int                        point_total;
   rsp_word_type              due_answers [$];

   initial begin
      fail_count  = 0;
      rsp_pending = 0;
      point_total = 0;
   end

   task automatic report_mismatch(string field, longint got_v, longint want_v);
      if (fail_count < PRINT_CAP) begin
         $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, field, got_v, want_v);
      end
      fail_count++;
   endtask

   // Apply one request to the predicted store and queue the words it causes.
   function automatic void apply_point_op(logic [FW-1:0] op,
                                          logic signed [COORD_W-1:0] px,
                                          logic signed [COORD_W-1:0] py,
                                          logic signed [COORD_W-1:0] rad);
      rsp_word_type w;
      longint       lim;
      longint       sx;
      longint       sy;
      int           hits;
      bit           found;
      bit           single;
      w.status    = psrq_pkg::STAT_OK;
      w.has_point = 1'b0;
      w.x         = '0;
      w.y         = '0;
      w.tally     = '0;
      w.last      = 1'b1;
      hits        = 0;
      found       = 1'b0;
      single      = 1'b1;
      case (op)
         psrq_pkg::FUNC_PUSH: begin
            if (point_total >= DEPTH) begin
               w.status = psrq_pkg::STAT_FULL;
            end else begin
               stored_x[point_total] = px;
               stored_y[point_total] = py;
               point_total++;
            end
         end
         psrq_pkg::FUNC_POP: begin
            if (point_total == 0) w.status = psrq_pkg::STAT_EMPTY;
            else point_total--;
         end
         psrq_pkg::FUNC_DELETE: begin
            if (point_total == 0) begin
               w.status = psrq_pkg::STAT_EMPTY;
            end else begin
               // remove the newest equal entry and close up the newer ones
               for (int j = point_total - 1; j >= 0 && !found; j--) begin
                  if (stored_x[j] == px && stored_y[j] == py) begin
                     for (int k = j; k < point_total - 1; k++) begin
                        stored_x[k] = stored_x[k+1];
                        stored_y[k] = stored_y[k+1];
                     end
                     point_total--;
                     found = 1'b1;
                  end
               end
               if (!found) w.status = psrq_pkg::STAT_NOT_FOUND;
            end
         end
         psrq_pkg::FUNC_RADIUS: begin
            lim = rad;
            lim = lim * lim;
            if (point_total == 0) begin
               w.status = psrq_pkg::STAT_EMPTY;
            end else begin
               for (int j = point_total - 1; j >= 0; j--) begin
                  sx = stored_x[j];
                  sy = stored_y[j];
                  if (sx * sx + sy * sy <= lim) begin
                     rsp_word_type hit_w;
                     hit_w           = w;
                     hit_w.has_point = 1'b1;
                     hit_w.x         = stored_x[j];
                     hit_w.y         = stored_y[j];
                     hit_w.last      = 1'b0;
                     due_answers.push_back(hit_w);
                     hits++;
                  end
               end
               if (hits == 0) begin
                  w.status = psrq_pkg::STAT_NO_RANGE;
               end else begin
                  due_answers[due_answers.size()-1].last = 1'b1;
                  single = 1'b0;
               end
            end
         end
         psrq_pkg::FUNC_COUNT: begin
            for (int j = 0; j < point_total; j++) begin
               if (stored_x[j] == px && stored_y[j] == py) hits++;
            end
            w.tally = hits[TLW-1:0];
         end
         psrq_pkg::FUNC_LENGTH: begin
            w.tally = point_total[TLW-1:0];
         end
         default: begin
            // undefined codes are dropped without a word
            single = 1'b0;
         end
      endcase
      if (single) due_answers.push_back(w);
   endfunction

   always @(posedge clock) begin : monitor
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         due_answers.delete();
         point_total = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.x         = rsp_tdata[COORD_W-1:0];
            got.y         = rsp_tdata[2*COORD_W-1:COORD_W];
            got.tally     = rsp_tdata[2*COORD_W+TLW-1:2*COORD_W];
            got.status    = rsp_tuser[STW-1:0];
            got.has_point = rsp_tuser[STW];
            got.last      = rsp_tlast;
            if (due_answers.size() == 0) begin
               report_mismatch("unexpected word, status", got.status, -1);
            end else begin
               want = due_answers.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.has_point !== want.has_point)
                  report_mismatch("has_point", got.has_point, want.has_point);
               if (got.x !== want.x) report_mismatch("out_x", got.x, want.x);
               if (got.y !== want.y) report_mismatch("out_y", got.y, want.y);
               if (got.tally !== want.tally) report_mismatch("tally", got.tally, want.tally);
               if (got.last !== want.last) report_mismatch("last", got.last, want.last);
            end
         end
         if (req_tvalid && req_tready) begin
            apply_point_op(req_tuser, req_tdata[COORD_W-1:0],
                           req_tdata[2*COORD_W-1:COORD_W], req_tdata[3*COORD_W-1:2*COORD_W]);
         end
      end
      rsp_pending = due_answers.size();
   end

endmodule

/* tb/tb.sv */
// Testbench top: drives requests and response back-pressure for the point store.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH          = 16;
   localparam int COORD_W        = 16;
   localparam int FW             = psrq_pkg::FUNC_W;
   localparam int REQ_W          = ((3*COORD_W+7)/8)*8;
   localparam int RSP_W          = ((2*COORD_W+psrq_pkg::TALLY_W+7)/8)*8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int PHASE_ITEMS    = 100;
   localparam int RECENT_MAX     = 8;

   localparam logic [FW-1:0] FUNC_UNUSED_LO = 3'd6;
   localparam logic [FW-1:0] FUNC_UNUSED_HI = 3'd7;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [REQ_W-1:0]              req_tdata;
   logic [FW-1:0]                 req_tuser;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [RSP_W-1:0]              rsp_tdata;
   logic [psrq_pkg::STATUS_W:0]   rsp_tuser;
   logic                          rsp_tlast;
   int                            fail_count;
   int                            rsp_pending;

   int                            send_idle_pct;
   int                            recv_stall_pct;
   int                            holdoff_left;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   point_type recent_points [$];

   point_store_radius_query #(
      .DEPTH       (DEPTH),
      .COORD_WIDTH (COORD_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   point_store_radius_query_checker #(
      .DEPTH   (DEPTH),
      .COORD_W (COORD_W),
      .REQ_W   (REQ_W),
      .RSP_W   (RSP_W)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .rsp_pending (rsp_pending)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Response side: random stalls, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_tready <= 1'b0;
         holdoff_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_word(logic [FW-1:0] op, logic signed [COORD_W-1:0] px,
                            logic signed [COORD_W-1:0] py, logic signed [COORD_W-1:0] rad);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {rad, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold the request side until every predicted word has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (rsp_pending != 0) @(negedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] pick_coord();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return COORD_W'(int'($urandom_range(400)) - 200);
      if (roll < 85) return COORD_W'($urandom);
      case ($urandom_range(3))
         0: return {1'b0, {(COORD_W-1){1'b1}}};
         1: return {1'b1, {(COORD_W-1){1'b0}}};
         2: return '0;
         default: return '1;
      endcase
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_radius();
      logic signed [COORD_W-1:0] r;
      if ($urandom_range(99) < 60) begin
         r = COORD_W'(int'($urandom_range(300)));
         if ($urandom_range(1)) r = -r;
      end else begin
         r = COORD_W'($urandom);
      end
      return r;
   endfunction

   task automatic send_random_item();
      int                        roll;
      logic [FW-1:0]             op;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      point_type                 p;
      roll = $urandom_range(99);
      px   = pick_coord();
      py   = pick_coord();
      if (roll < 30) op = psrq_pkg::FUNC_PUSH;
      else if (roll < 42) op = psrq_pkg::FUNC_POP;
      else if (roll < 57) op = psrq_pkg::FUNC_DELETE;
      else if (roll < 75) op = psrq_pkg::FUNC_RADIUS;
      else if (roll < 87) op = psrq_pkg::FUNC_COUNT;
      else if (roll < 95) op = psrq_pkg::FUNC_LENGTH;
      else op = $urandom_range(1) ? FUNC_UNUSED_LO : FUNC_UNUSED_HI;
      // aim most deletes and counts at points that were pushed recently
      if ((op == psrq_pkg::FUNC_DELETE || op == psrq_pkg::FUNC_COUNT)
          && recent_points.size() != 0 && $urandom_range(99) < 70) begin
         p  = recent_points[$urandom_range(recent_points.size() - 1)];
         px = p.x;
         py = p.y;
      end
      if (op == psrq_pkg::FUNC_PUSH) begin
         p.x = px;
         p.y = py;
         recent_points.push_back(p);
         if (recent_points.size() > RECENT_MAX) void'(recent_points.pop_front());
      end
      send_word(op, px, py, pick_radius());
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = psrq_pkg::FUNC_PUSH;
      rsp_tready     = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      holdoff_left   = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty store
      send_word(psrq_pkg::FUNC_LENGTH, 0, 0, 0);
      send_word(psrq_pkg::FUNC_POP, 0, 0, 0);
      send_word(psrq_pkg::FUNC_DELETE, 1, 1, 0);
      send_word(psrq_pkg::FUNC_RADIUS, 0, 0, 5);
      send_word(psrq_pkg::FUNC_COUNT, 1, 1, 0);
      // extremes and small points
      send_word(psrq_pkg::FUNC_PUSH, 32767, -32768, 0);
      send_word(psrq_pkg::FUNC_PUSH, -32768, 32767, 0);
      send_word(psrq_pkg::FUNC_PUSH, 0, 0, 0);
      send_word(psrq_pkg::FUNC_PUSH, 3, 4, 0);
      send_word(psrq_pkg::FUNC_PUSH, -3, -4, 0);
      send_word(psrq_pkg::FUNC_RADIUS, 0, 0, 5);
      send_word(psrq_pkg::FUNC_RADIUS, 0, 0, -5);
      send_word(psrq_pkg::FUNC_RADIUS, 0, 0, 32767);
      send_word(psrq_pkg::FUNC_RADIUS, 0, 0, -32768);
      send_word(psrq_pkg::FUNC_COUNT, 3, 4, 0);
      send_word(psrq_pkg::FUNC_DELETE, 3, 4, 0);
      send_word(psrq_pkg::FUNC_DELETE, 3, 4, 0);
      send_word(psrq_pkg::FUNC_DELETE, 0, 0, 0);
      send_word(psrq_pkg::FUNC_DELETE, -3, -4, 0);
      send_word(psrq_pkg::FUNC_RADIUS, 0, 0, 1);
      send_word(FUNC_UNUSED_LO, 1, 2, 3);
      send_word(FUNC_UNUSED_HI, -1, -2, -3);
      repeat (3) send_word(psrq_pkg::FUNC_POP, 0, 0, 0);
      // fill with one point past full, then list and empty it
      repeat (DEPTH + 1) send_word(psrq_pkg::FUNC_PUSH, 5, -5, 0);
      send_word(psrq_pkg::FUNC_COUNT, 5, -5, 0);
      send_word(psrq_pkg::FUNC_LENGTH, 0, 0, 0);
      send_word(psrq_pkg::FUNC_RADIUS, 0, 0, 8);
      repeat (DEPTH) send_word(psrq_pkg::FUNC_POP, 0, 0, 0);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // stall the response side for a long stretch while requests keep coming
            if (phase == 0 && n == PHASE_ITEMS / 2) holdoff_left = HOLDOFF_CYCLES;
            send_random_item();
         end
         wait_drained();
      end

      recv_stall_pct = 0;
      repeat (DEPTH + 8) @(negedge clock);
      if (fail_count == 0 && rsp_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
